FILE: src/otpc_pkg.sv
// Package for the one-wire temperature poll controller.
// Item structs, configuration struct, code enums and constants.
// No dependencies; used by every module under src.
package otpc_pkg;

  typedef enum logic [1:0] {
    KIND_INIT     = 2'd0,
    KIND_POLL     = 2'd1,
    KIND_PRESENCE = 2'd2,
    KIND_BYTE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CONVERT = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_INIT_CONV = 3'd1,
    PH_POLL_CONV = 3'd2,
    PH_READ_PRES = 3'd3,
    PH_READING   = 3'd4
  } phase_e;

  // configuration register indexes
  localparam logic [1:0] CFG_CONVERT_WAIT    = 2'd0;
  localparam logic [1:0] CFG_POLL_INTERVAL   = 2'd1;
  localparam logic [1:0] CFG_INVALID_READING = 2'd2;

  localparam int unsigned CfgDataWidth = 32;

  localparam logic [15:0]        CONVERT_WAIT_RST    = 16'd750;
  localparam logic [31:0]        POLL_INTERVAL_RST   = 32'd1000;
  localparam logic signed [15:0] INVALID_READING_RST = 16'sh8000;

  // Dallas CRC-8, reflected
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // scratchpad byte positions
  localparam logic [3:0] SP_TEMP_LSB = 4'd0;
  localparam logic [3:0] SP_TEMP_MSB = 4'd1;
  localparam logic [3:0] SP_CONFIG   = 4'd7;
  localparam logic [3:0] SP_CRC      = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        present;
    logic [7:0]  scratch_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] temp_sixteenths;
    logic               temp_valid;
    logic               crc_error;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        convert_wait_ms;
    logic [31:0]        poll_interval_ms;
    logic signed [15:0] invalid_reading;
  } cfg_t;

endpackage

FILE: src/otpc_crc8.sv
// One-byte update of the Dallas CRC-8 (reflected 0x8C), LSB first.
// Depends on otpc_pkg.
module otpc_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);
  import otpc_pkg::*;

  logic [7:0] crc_v;
  logic [7:0] data_v;
  logic       mix;

  always_comb begin
    crc_v  = crc_i;
    data_v = data_i;
    mix    = 1'b0;
    for (int k = 0; k < 8; k++) begin
      mix    = crc_v[0] ^ data_v[0];
      crc_v  = {1'b0, crc_v[7:1]};
      if (mix) begin
        crc_v = crc_v ^ CRC_POLY;
      end
      data_v = {1'b0, data_v[7:1]};
    end
    crc_o = crc_v;
  end

endmodule

FILE: src/otpc_ctrl.sv
// Controller state and per-item decision logic: phase machine, poll timing,
// scratchpad capture and check. Depends on otpc_pkg and otpc_crc8.
module otpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  otpc_pkg::in_item_t  item_i,
  input  otpc_pkg::cfg_t      cfg_i,
  output otpc_pkg::out_item_t result_o
);
  import otpc_pkg::*;

  phase_e             phase_q, phase_d;
  logic               pending_q, pending_d;
  logic [31:0]        last_time_q, last_time_d;
  logic [31:0]        poll_time_q, poll_time_d;
  logic [3:0]         byte_idx_q, byte_idx_d;
  logic [7:0]         crc_q, crc_d;
  logic [15:0]        raw_q, raw_d;
  logic [7:0]         cfg_cap_q, cfg_cap_d;
  logic signed [15:0] temp_q, temp_d;
  logic               valid_q, valid_d;

  action_e     action;
  logic        crc_err;
  logic [7:0]  crc_next;
  logic [31:0] elapsed;
  logic [31:0] resume_elapsed;
  logic        time_unset;
  logic        read_due;
  logic        conv_due;
  logic        resume_due;
  phase_e      resume_phase;
  logic        in_body;

  otpc_crc8 u_crc (
    .crc_i  (crc_q),
    .data_i (item_i.scratch_byte),
    .crc_o  (crc_next)
  );

  assign elapsed        = item_i.now_ms - last_time_q;
  assign resume_elapsed = poll_time_q - last_time_q;
  assign time_unset     = (last_time_q == '0);
  assign read_due       = pending_q && (elapsed >= {16'b0, cfg_i.convert_wait_ms});
  assign conv_due       = !pending_q && (elapsed >= cfg_i.poll_interval_ms);
  // pending is always cleared when a read ends, so only the interval matters
  assign resume_due     = (resume_elapsed >= cfg_i.poll_interval_ms);
  assign resume_phase   = resume_due ? PH_POLL_CONV : PH_IDLE;
  assign in_body        = (byte_idx_q < SP_CRC);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      case (item_i.kind)
        KIND_INIT: phase_d = PH_INIT_CONV;
        KIND_POLL: begin
          if (phase_q == PH_IDLE && !time_unset) begin
            if (read_due) begin
              phase_d = PH_READ_PRES;
            end else if (conv_due) begin
              phase_d = PH_POLL_CONV;
            end
          end
        end
        KIND_PRESENCE: begin
          unique case (phase_q)
            PH_INIT_CONV, PH_POLL_CONV: phase_d = PH_IDLE;
            PH_READ_PRES: phase_d = item_i.present ? PH_READING : resume_phase;
            default: ;
          endcase
        end
        KIND_BYTE: begin
          if (phase_q == PH_READING && !in_body) begin
            phase_d = resume_phase;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath updates and the result
  always_comb begin
    pending_d   = pending_q;
    last_time_d = last_time_q;
    poll_time_d = poll_time_q;
    byte_idx_d  = byte_idx_q;
    crc_d       = crc_q;
    raw_d       = raw_q;
    cfg_cap_d   = cfg_cap_q;
    temp_d      = temp_q;
    valid_d     = valid_q;
    action      = ACT_NONE;
    crc_err     = 1'b0;
    if (fire_i) begin
      case (item_i.kind)
        KIND_INIT: begin
          valid_d    = 1'b0;
          temp_d     = cfg_i.invalid_reading;
          pending_d  = 1'b0;
          byte_idx_d = '0;
          action     = ACT_CONVERT;
        end
        KIND_POLL: begin
          if (phase_q == PH_IDLE) begin
            if (time_unset) begin
              last_time_d = item_i.now_ms;
            end else if (read_due) begin
              poll_time_d = item_i.now_ms;
              action      = ACT_READ;
            end else if (conv_due) begin
              last_time_d = item_i.now_ms;
              action      = ACT_CONVERT;
            end
          end
        end
        KIND_PRESENCE: begin
          unique case (phase_q)
            PH_INIT_CONV: begin
              if (item_i.present) begin
                pending_d   = 1'b1;
                last_time_d = '0;
              end
            end
            PH_POLL_CONV: begin
              if (item_i.present) begin
                pending_d = 1'b1;
              end
            end
            PH_READ_PRES: begin
              if (item_i.present) begin
                byte_idx_d = '0;
                crc_d      = '0;
              end else begin
                // no device on the read: failed read, then the poll goes on
                valid_d   = 1'b0;
                temp_d    = cfg_i.invalid_reading;
                pending_d = 1'b0;
                if (resume_due) begin
                  last_time_d = poll_time_q;
                  action      = ACT_CONVERT;
                end
              end
            end
            default: ;
          endcase
        end
        KIND_BYTE: begin
          if (phase_q == PH_READING) begin
            if (in_body) begin
              crc_d = crc_next;
              if (byte_idx_q == SP_TEMP_LSB) begin
                raw_d[7:0] = item_i.scratch_byte;
              end else if (byte_idx_q == SP_TEMP_MSB) begin
                raw_d[15:8] = item_i.scratch_byte;
              end else if (byte_idx_q == SP_CONFIG) begin
                cfg_cap_d = item_i.scratch_byte;
              end
              byte_idx_d = byte_idx_q + 4'd1;
            end else begin
              if (crc_q != item_i.scratch_byte) begin
                crc_err = 1'b1;
                valid_d = 1'b0;
                temp_d  = cfg_i.invalid_reading;
              end else if (cfg_cap_q != '0) begin
                temp_d  = raw_q;
                valid_d = 1'b1;
              end else begin
                valid_d = 1'b0;
                temp_d  = cfg_i.invalid_reading;
              end
              byte_idx_d = '0;
              pending_d  = 1'b0;
              if (resume_due) begin
                last_time_d = poll_time_q;
                action      = ACT_CONVERT;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result_o.action          = action;
  assign result_o.temp_sixteenths = valid_d ? temp_d : cfg_i.invalid_reading;
  assign result_o.temp_valid      = valid_d;
  assign result_o.crc_error       = crc_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pending_q   <= 1'b0;
      last_time_q <= '0;
      byte_idx_q  <= '0;
      valid_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      last_time_q <= last_time_d;
      byte_idx_q  <= byte_idx_d;
      valid_q     <= valid_d;
    end
  end

  // payload: each is written before it is read
  always_ff @(posedge clk_i) begin
    poll_time_q <= poll_time_d;
    crc_q       <= crc_d;
    raw_q       <= raw_d;
    cfg_cap_q   <= cfg_cap_d;
    temp_q      <= temp_d;
  end

endmodule

FILE: src/onewire_temp_poll_controller_unit.sv
// Top level of the one-wire temperature poll controller: input register,
// configuration registers, result register. Depends on otpc_pkg, otpc_ctrl.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries init, poll,
//   presence and scratchpad-byte items. Output channel (out_valid_o/
//   out_ready_i/out_item_o) returns exactly one result per item: the bus
//   action to issue, the current temperature in 1/16 degree and its flags.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the clock edge; write only while no item is in flight.
//   An accepted item waits in the input register and its result is
//   captured in the result register. Throughput: one item per cycle while
//   the result register is free or being read; the whole decision is one
//   pass of compare/subtract logic between the input and result registers.
//   Reset: poll timer unset, no conversion pending, reading invalid,
//   registers back to 750 ms wait, 1000 ms interval, invalid value -32768.
//   Stall: the result register holds while out_ready_i is low; one more item
//   waits in the input register, then in_ready_o drops.
module onewire_temp_poll_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  otpc_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output otpc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [otpc_pkg::CfgDataWidth-1:0] cfg_wdata_i
);
  import otpc_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  cfg_t      cfg_q;
  logic      proc_fire;
  logic      in_fire;

  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  otpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (proc_fire),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_i;
    end
    if (proc_fire) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.convert_wait_ms  <= CONVERT_WAIT_RST;
      cfg_q.poll_interval_ms <= POLL_INTERVAL_RST;
      cfg_q.invalid_reading  <= INVALID_READING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONVERT_WAIT:    cfg_q.convert_wait_ms  <= cfg_wdata_i[15:0];
        CFG_POLL_INTERVAL:   cfg_q.poll_interval_ms <= cfg_wdata_i[31:0];
        CFG_INVALID_READING: cfg_q.invalid_reading  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // a decided item always lands in the result register
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> out_valid_q)
    else $error("decided item did not reach result register");

  // a waiting input item is never dropped before it is decided
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> in_valid_q)
    else $error("input item lost");

  // a CRC failure never leaves the reading marked valid
  a_crc_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.crc_error) |-> !out_q.temp_valid)
    else $error("crc error with valid reading");

  // a read that ends in a CRC failure never asks for another read
  a_crc_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.crc_error) |-> (out_q.action != ACT_READ))
    else $error("read requested on read completion");
`endif

endmodule

FILE: sim/tb_onewire_temp_poll_controller_unit.sv
// Testbench for onewire_temp_poll_controller_unit: a directed run and random
// one-wire conversations checked item by item against a behavioral predictor.
// Depends on otpc_pkg and the unit under src.
`timescale 1ns / 1ps

module tb_onewire_temp_poll_controller_unit;
  import otpc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  onewire_temp_poll_controller_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted controller state and register copy
  cfg_t               m_cfg = '{CONVERT_WAIT_RST, POLL_INTERVAL_RST, INVALID_READING_RST};
  phase_e             m_phase = PH_IDLE;
  logic               m_conv_pending = 1'b0;
  logic [31:0]        m_last_ms = '0;
  logic [31:0]        m_poll_ms = '0;
  logic [3:0]         m_sp_index = '0;
  logic [7:0]         m_crc = '0;
  logic [15:0]        m_raw = '0;
  logic [7:0]         m_cfg_byte = '0;
  logic signed [15:0] m_temp = INVALID_READING_RST;
  logic               m_temp_ok = 1'b0;

  in_item_t  bus_items[$];
  out_item_t expected_readings[$];
  int        issued_count = 0;
  int        accepted_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  logic      in_accepted = 1'b0;
  logic      out_accepted = 1'b0;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic mix;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) crc = crc ^ CRC_POLY;
      b = b >> 1;
    end
    return crc;
  endfunction

  task automatic drop_reading();
    m_temp_ok = 1'b0;
    m_temp    = m_cfg.invalid_reading;
  endtask

  // the poll that asked for a read goes on with its own time
  task automatic resume_poll(output logic [1:0] act);
    if (!m_conv_pending && (m_poll_ms - m_last_ms) >= m_cfg.poll_interval_ms) begin
      m_last_ms = m_poll_ms;
      m_phase   = PH_POLL_CONV;
      act       = ACT_CONVERT;
    end else begin
      m_phase = PH_IDLE;
      act     = ACT_NONE;
    end
  endtask

  task automatic predict_sensor_item(input in_item_t it);
    out_item_t   res;
    logic [31:0] elapsed;
    res = '0;
    res.action = ACT_NONE;
    elapsed = it.now_ms - m_last_ms;
    case (it.kind)
      KIND_INIT: begin
        drop_reading();
        m_conv_pending = 1'b0;
        m_sp_index     = '0;
        m_phase        = PH_INIT_CONV;
        res.action     = ACT_CONVERT;
      end
      KIND_POLL: begin
        if (m_phase == PH_IDLE) begin
          if (m_last_ms == '0) begin
            m_last_ms = it.now_ms;
          end else if (m_conv_pending && elapsed >= {16'd0, m_cfg.convert_wait_ms}) begin
            m_poll_ms  = it.now_ms;
            m_phase    = PH_READ_PRES;
            res.action = ACT_READ;
          end else if (!m_conv_pending && elapsed >= m_cfg.poll_interval_ms) begin
            m_last_ms  = it.now_ms;
            m_phase    = PH_POLL_CONV;
            res.action = ACT_CONVERT;
          end
        end
      end
      KIND_PRESENCE: begin
        case (m_phase)
          PH_INIT_CONV: begin
            if (it.present) begin
              m_conv_pending = 1'b1;
              m_last_ms      = '0;
            end
            m_phase = PH_IDLE;
          end
          PH_POLL_CONV: begin
            if (it.present) m_conv_pending = 1'b1;
            m_phase = PH_IDLE;
          end
          PH_READ_PRES: begin
            if (it.present) begin
              m_sp_index = '0;
              m_crc      = '0;
              m_phase    = PH_READING;
            end else begin
              drop_reading();
              m_conv_pending = 1'b0;
              resume_poll(res.action);
            end
          end
          default: ;
        endcase
      end
      KIND_BYTE: begin
        if (m_phase == PH_READING) begin
          if (m_sp_index < SP_CRC) begin
            m_crc = crc8_step(m_crc, it.scratch_byte);
            if (m_sp_index == SP_TEMP_LSB) m_raw[7:0] = it.scratch_byte;
            else if (m_sp_index == SP_TEMP_MSB) m_raw[15:8] = it.scratch_byte;
            else if (m_sp_index == SP_CONFIG) m_cfg_byte = it.scratch_byte;
            m_sp_index = m_sp_index + 4'd1;
          end else begin
            if (m_crc != it.scratch_byte) begin
              res.crc_error = 1'b1;
              drop_reading();
            end else if (m_cfg_byte != 8'h00) begin
              m_temp    = m_raw;
              m_temp_ok = 1'b1;
            end else begin
              drop_reading();
            end
            m_sp_index     = '0;
            m_conv_pending = 1'b0;
            resume_poll(res.action);
          end
        end
      end
    endcase
    res.temp_valid      = m_temp_ok;
    res.temp_sixteenths = m_temp_ok ? m_temp : m_cfg.invalid_reading;
    expected_readings.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  // Monitor: rising edge sampling, result check, prediction of accepted items
  always @(posedge clk) begin : monitor
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      in_accepted  = in_valid && in_ready;
      out_accepted = out_valid && out_ready;
      if (out_accepted) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_readings.pop_front();
          if (out_item.action !== want.action)
            report_mismatch($sformatf("action %0d, want %0d", out_item.action, want.action));
          if (out_item.temp_sixteenths !== want.temp_sixteenths)
            report_mismatch($sformatf("temp %0d, want %0d",
                                      out_item.temp_sixteenths, want.temp_sixteenths));
          if (out_item.temp_valid !== want.temp_valid)
            report_mismatch($sformatf("temp_valid %b, want %b",
                                      out_item.temp_valid, want.temp_valid));
          if (out_item.crc_error !== want.crc_error)
            report_mismatch($sformatf("crc_error %b, want %b",
                                      out_item.crc_error, want.crc_error));
        end
      end
      if (in_accepted) begin
        predict_sensor_item(in_item);
        accepted_count++;
      end
    end
  end

  // Driver: one item at a time from bus_items, random gap after each item
  int   in_gap = 0;
  logic in_calm = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bus_items.size() != 0) begin
          in_item  <= bus_items.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall before each result
  int   out_stall = 0;
  logic out_calm = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_accepted) begin
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [31:0] now_ms,
                           input logic present, input logic [7:0] sb);
    in_item_t it;
    it.kind         = kind;
    it.now_ms       = now_ms;
    it.present      = present;
    it.scratch_byte = sb;
    bus_items.push_back(it);
    issued_count++;
  endtask

  task automatic settle();
    while (accepted_count != issued_count || expected_readings.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CONVERT_WAIT:    m_cfg.convert_wait_ms  = data[15:0];
      CFG_POLL_INTERVAL:   m_cfg.poll_interval_ms = data;
      CFG_INVALID_READING: m_cfg.invalid_reading  = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // poll times aimed at the wait and interval thresholds, plus wrap and zero
  task automatic queue_poll();
    logic [31:0] t, span;
    span = (m_cfg.poll_interval_ms > {16'd0, m_cfg.convert_wait_ms}) ?
           m_cfg.poll_interval_ms : {16'd0, m_cfg.convert_wait_ms};
    if (span > 32'd100000) span = 32'd100000;
    case ($urandom_range(0, 11))
      0: t = 32'd0;
      1: t = $urandom();
      2: t = m_last_ms + {16'd0, m_cfg.convert_wait_ms};
      3: t = m_last_ms + {16'd0, m_cfg.convert_wait_ms} - 32'd1;
      4: t = m_last_ms + m_cfg.poll_interval_ms;
      5: t = m_last_ms + m_cfg.poll_interval_ms - 32'd1;
      6: t = m_last_ms + $urandom_range(0, 3);
      7: t = m_last_ms - $urandom_range(1, 4);
      8: t = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: t = m_last_ms + $urandom_range(0, 2 * span + 2);
    endcase
    push_item(KIND_POLL, t, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_scratchpad();
    logic [7:0] sp [0:8];
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 8; i++) sp[i] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: begin sp[SP_TEMP_LSB] = 8'h00; sp[SP_TEMP_MSB] = 8'h80; end
      1: begin sp[SP_TEMP_LSB] = 8'hFF; sp[SP_TEMP_MSB] = 8'h7F; end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) sp[SP_CONFIG] = 8'h00;
    for (int i = 0; i < 8; i++) crc = crc8_step(crc, sp[i]);
    sp[SP_CRC] = crc;
    if ($urandom_range(0, 4) == 0) sp[SP_CRC] = crc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 9; i++) begin
      // stray items while the bus is busy are ignored
      if ($urandom_range(0, 11) == 0) queue_poll();
      if ($urandom_range(0, 39) == 0) push_item(KIND_PRESENCE, $urandom(), 1'b1, 8'h00);
      push_item(KIND_BYTE, $urandom(), 1'($urandom_range(0, 1)), sp[i]);
    end
  endtask

  // Mostly well-formed conversations steered by the predicted phase
  task automatic run_random(input int n);
    int target, pick;
    target = issued_count + n;
    while (issued_count < target) begin
      while (accepted_count != issued_count) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_item(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 11) begin
        push_item(KIND_INIT, $urandom(), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
      end else begin
        case (m_phase)
          PH_IDLE: queue_poll();
          PH_READ_PRES: begin
            if ($urandom_range(0, 7) == 0) begin
              push_item(KIND_PRESENCE, $urandom(), 1'b0, 8'($urandom_range(0, 255)));
            end else begin
              push_item(KIND_PRESENCE, $urandom(), 1'b1, 8'($urandom_range(0, 255)));
              queue_scratchpad();
            end
          end
          PH_READING: begin
            repeat (9 - m_sp_index)
              push_item(KIND_BYTE, $urandom(), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)));
          end
          default: begin
            if ($urandom_range(0, 5) == 0) queue_poll();
            push_item(KIND_PRESENCE, $urandom(), $urandom_range(0, 7) != 0,
                      8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] dir_sp [0:8];
    logic [7:0] crc;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed run at reset settings (750 ms wait, 1000 ms interval)
    push_item(KIND_POLL, 32'd0, 1'b0, 8'h00);         // time zero stays unset
    push_item(KIND_PRESENCE, 32'd0, 1'b1, 8'h00);     // out of phase
    push_item(KIND_BYTE, 32'd0, 1'b0, 8'hFF);         // out of phase
    push_item(KIND_POLL, 32'd100, 1'b0, 8'h00);       // arms the timer
    push_item(KIND_POLL, 32'd1099, 1'b0, 8'h00);
    push_item(KIND_POLL, 32'd1100, 1'b1, 8'h00);      // conversion start
    push_item(KIND_POLL, 32'hFFFF_FFFF, 1'b1, 8'hFF); // bus busy
    push_item(KIND_PRESENCE, 32'd0, 1'b1, 8'h00);
    push_item(KIND_POLL, 32'd1849, 1'b0, 8'h00);
    push_item(KIND_POLL, 32'd1850, 1'b0, 8'h00);      // read request
    push_item(KIND_BYTE, 32'd0, 1'b0, 8'h55);         // before presence, ignored
    push_item(KIND_PRESENCE, 32'd0, 1'b1, 8'h00);
    dir_sp = '{8'h90, 8'hFC, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10, 8'h00};
    crc = '0;
    for (int i = 0; i < 8; i++) crc = crc8_step(crc, dir_sp[i]);
    dir_sp[SP_CRC] = crc;
    for (int i = 0; i < 9; i++) push_item(KIND_BYTE, 32'd0, 1'b0, dir_sp[i]);
    push_item(KIND_INIT, 32'd0, 1'b0, 8'h00);
    push_item(KIND_PRESENCE, 32'd0, 1'b0, 8'h00);     // no device on init start
    run_random(190);
    settle();

    write_reg(CFG_CONVERT_WAIT, 32'd0);
    write_reg(CFG_POLL_INTERVAL, 32'd0);
    write_reg(CFG_INVALID_READING, 32'h0000_7FFF);
    run_random(190);
    settle();

    write_reg(CFG_CONVERT_WAIT, 32'h0000_FFFF);
    write_reg(CFG_POLL_INTERVAL, 32'hFFFF_FFFF);
    write_reg(CFG_INVALID_READING, 32'h0000_0000);
    run_random(190);
    settle();

    write_reg(CFG_CONVERT_WAIT, $urandom_range(1, 40));
    write_reg(CFG_POLL_INTERVAL, $urandom_range(1, 120));
    write_reg(CFG_INVALID_READING, $urandom());
    run_random(190);
    settle();

    write_reg(CFG_CONVERT_WAIT, $urandom_range(0, 2000));
    write_reg(CFG_POLL_INTERVAL, $urandom_range(0, 3000));
    write_reg(CFG_INVALID_READING, 32'hFFFF_8000);
    run_random(190);
    settle();
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
